/* hw/rtl/fdsm_pkg.sv */
// ----------------------------------------------------------------------------
// fdsm_pkg
// Shared widths, codes and digit tables for the four-digit display driver.
// ----------------------------------------------------------------------------
package fdsm_pkg;

    // field widths
    localparam int CMD_W      = 3;
    localparam int MINUTES_W  = 6;
    localparam int HOURS_W    = 7;
    localparam int ENABLE_W   = 4;
    localparam int SEG_W      = 8;
    localparam int TICK_MS_W  = 10;
    localparam int SPLASH_W   = 14;
    localparam int ELAPSED_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TURN_ON   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TURN_OFF  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_HOURS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEC_HOURS = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICK_MS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPLASH_MS = 1'd1;

    // display modes
    localparam logic [1:0] MODE_SPLASH  = 2'd0;
    localparam logic [1:0] MODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_STOPPED = 2'd2;

    // reset values and limits
    localparam logic [TICK_MS_W-1:0] TICK_MS_RESET   = 10'd5;
    localparam logic [SPLASH_W-1:0]  SPLASH_MS_RESET = 14'd10000;
    localparam logic [MINUTES_W-1:0] MINUTES_PER_HR  = 6'd60;
    localparam logic [HOURS_W-1:0]   HOURS_MAX       = 7'd99;

    // fixed patterns
    localparam logic [SEG_W-1:0] SPLASH_PAT_A = 8'b0011_0000;
    localparam logic [SEG_W-1:0] SPLASH_PAT_B = 8'b0111_0110;

    // decimal digit to segment pattern, bit0 is segment a
    function automatic logic [SEG_W-1:0] digit_seg(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h3F;
        endcase
        return s;
    endfunction

    // tens digit of a value below 128, by independent compares
    function automatic logic [3:0] tens_of(input logic [HOURS_W-1:0] v);
        logic [3:0] t;
        t = 4'd0;
        for (int k = 1; k < 13; k++) begin
            if (v >= HOURS_W'(k * 10)) begin
                t = 4'(k);
            end
        end
        return t;
    endfunction

endpackage

/* hw/rtl/fdsm_in_if.sv */
// ----------------------------------------------------------------------------
// fdsm_in_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface fdsm_in_if
    import fdsm_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [MINUTES_W-1:0] minutes_counter;
    logic [HOURS_W-1:0]   hours_value;

    modport source (output valid, output cmd, output minutes_counter,
                    output hours_value, input ready);
    modport sink   (input valid, input cmd, input minutes_counter,
                    input hours_value, output ready);
endinterface

/* hw/rtl/fdsm_out_if.sv */
// ----------------------------------------------------------------------------
// fdsm_out_if
// Display channel: valid/ready handshake with digit enables and segments.
// ----------------------------------------------------------------------------
interface fdsm_out_if
    import fdsm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ENABLE_W-1:0] digit_enable;
    logic [SEG_W-1:0]    segments;

    modport source (output valid, output digit_enable, output segments, input ready);
    modport sink   (input valid, input digit_enable, input segments, output ready);
endinterface

/* hw/rtl/four_digit_ssd_multiplexer.sv */
// ----------------------------------------------------------------------------
// four_digit_ssd_multiplexer
// Four-digit multiplexed seven-segment driver for hours and minutes.
// ----------------------------------------------------------------------------
// One command item is taken per clock cycle while input ready is high. A tick
// item yields one display item in the output register on the next cycle;
// other commands yield none. Input ready is high whenever the output register
// is empty or is being drained in the same cycle, so with the sink always
// ready the sustained rate is one item per cycle. No clearing pass is needed
// after reset.
module four_digit_ssd_multiplexer
    import fdsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fdsm_in_if.sink               i_in,
    fdsm_out_if.source            o_out
);

    // configuration and state
    logic [TICK_MS_W-1:0] r_tick_ms;
    logic [SPLASH_W-1:0]  r_splash_ms;
    logic [1:0]           r_mode,      n_mode;
    logic                 r_sphase,    n_sphase;
    logic [1:0]           r_dphase,    n_dphase;
    logic [ELAPSED_W-1:0] r_elapsed,   n_elapsed;
    logic [HOURS_W-1:0]   r_hours,     n_hours;
    logic [SEG_W-1:0]     r_last_seg,  n_last_seg;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic [ENABLE_W-1:0]  r_out_en,    n_out_en;
    logic [SEG_W-1:0]     r_out_seg,   n_out_seg;

    logic                 w_accept;
    logic                 w_is_tick;
    logic [MINUTES_W-1:0] w_minutes;
    logic [HOURS_W-1:0]   w_min_ext;
    logic [3:0]           w_min_tens;
    logic [3:0]           w_min_ones;
    logic [3:0]           w_hr_tens;
    logic [3:0]           w_hr_ones;
    logic [ELAPSED_W:0]   w_sum;
    logic [ELAPSED_W-1:0] w_elapsed_sat;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_is_tick  = (i_in.cmd == CMD_TICK);

    // minutes shown from the remaining-minute counter
    always_comb begin
        if (i_in.minutes_counter == '0 || i_in.minutes_counter > MINUTES_PER_HR) begin
            w_minutes = '0;
        end else begin
            w_minutes = MINUTES_PER_HR - i_in.minutes_counter;
        end
    end

    // decimal split of minutes and hours
    assign w_min_ext  = {{(HOURS_W-MINUTES_W){1'b0}}, w_minutes};
    assign w_min_tens = tens_of(w_min_ext);
    assign w_min_ones = 4'(w_min_ext - HOURS_W'(w_min_tens) * HOURS_W'(10));
    assign w_hr_tens  = tens_of(r_hours);
    assign w_hr_ones  = 4'(r_hours - HOURS_W'(w_hr_tens) * HOURS_W'(10));

    // saturating splash time
    assign w_sum         = {1'b0, r_elapsed} + (ELAPSED_W+1)'(r_tick_ms);
    assign w_elapsed_sat = w_sum[ELAPSED_W] ? '1 : w_sum[ELAPSED_W-1:0];

    // command decode and next state
    always_comb begin
        n_mode      = r_mode;
        n_sphase    = r_sphase;
        n_dphase    = r_dphase;
        n_elapsed   = r_elapsed;
        n_hours     = r_hours;
        n_last_seg  = r_last_seg;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_en    = r_out_en;
        n_out_seg   = r_out_seg;
        if (w_accept) begin
            case (i_in.cmd)
                CMD_TURN_ON:   n_mode = MODE_SPLASH;
                CMD_TURN_OFF:  n_mode = MODE_STOPPED;
                CMD_SET_HOURS: begin
                    n_hours = (i_in.hours_value > HOURS_MAX) ? HOURS_MAX : i_in.hours_value;
                end
                CMD_DEC_HOURS: begin
                    if (r_hours != '0) begin
                        n_hours = r_hours - HOURS_W'(1);
                    end
                end
                CMD_TICK: begin
                    n_out_valid = 1'b1;
                    case (r_mode)
                        MODE_SPLASH: begin
                            if (!r_sphase) begin
                                n_out_en  = 4'b0010;
                                n_out_seg = SPLASH_PAT_A;
                            end else begin
                                n_out_en  = 4'b0100;
                                n_out_seg = SPLASH_PAT_B;
                            end
                            n_sphase = !r_sphase;
                            if (w_elapsed_sat >= ELAPSED_W'(r_splash_ms)) begin
                                n_elapsed = '0;
                                n_mode    = MODE_RUNNING;
                            end else begin
                                n_elapsed = w_elapsed_sat;
                            end
                        end
                        MODE_RUNNING: begin
                            case (r_dphase)
                                2'd0: begin
                                    n_out_en  = 4'b0001;
                                    n_out_seg = digit_seg(w_min_ones);
                                end
                                2'd1: begin
                                    n_out_en  = 4'b0010;
                                    n_out_seg = digit_seg(w_min_tens);
                                end
                                2'd2: begin
                                    n_out_en  = 4'b0100;
                                    n_out_seg = digit_seg(w_hr_ones);
                                end
                                default: begin
                                    n_out_en  = 4'b1000;
                                    n_out_seg = digit_seg(w_hr_tens);
                                end
                            endcase
                            n_dphase = r_dphase + 2'd1;
                        end
                        default: begin
                            n_out_en  = '0;
                            n_out_seg = r_last_seg;
                        end
                    endcase
                    n_last_seg = n_out_seg;
                end
                default: ;
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms   <= TICK_MS_RESET;
            r_splash_ms <= SPLASH_MS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TICK_MS:   r_tick_ms   <= i_cfg_data[TICK_MS_W-1:0];
                REG_SPLASH_MS: r_splash_ms <= i_cfg_data[SPLASH_W-1:0];
                default: ;
            endcase
        end
    end

    // display state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SPLASH;
            r_sphase    <= 1'b0;
            r_dphase    <= 2'd0;
            r_elapsed   <= '0;
            r_hours     <= '0;
            r_last_seg  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_sphase    <= n_sphase;
            r_dphase    <= n_dphase;
            r_elapsed   <= n_elapsed;
            r_hours     <= n_hours;
            r_last_seg  <= n_last_seg;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_out_en  <= n_out_en;
        r_out_seg <= n_out_seg;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.digit_enable = r_out_en;
    assign o_out.segments     = r_out_seg;

`ifndef SYNTHESIS
    // at most one digit lit per item
    a_enable_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(r_out_en))
        else $error("more than one digit enabled");

    // hours never leave the displayable range
    a_hours_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hours <= HOURS_MAX)
        else $error("hours out of range");

    // a tick while stopped blanks the display and repeats the last pattern
    a_stopped_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_tick && r_mode == MODE_STOPPED)
        |=> (r_out_valid && r_out_en == '0 && r_out_seg == $past(r_last_seg)))
        else $error("stopped tick not blank");

    // a command other than a tick produces no item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_tick && !r_out_valid) |=> !r_out_valid)
        else $error("item produced by non-tick command");
`endif

endmodule

/* tb/sv/fdsm_display_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdsm_display_checker
// Watches the command, display and register ports of the display driver,
// keeps its own model of modes, digits and hours, and compares every display
// item against the oldest predicted frame.
// ----------------------------------------------------------------------------
module fdsm_display_checker
    import fdsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fdsm_in_if                    i_cmd,
    fdsm_out_if                   i_disp,
    output int                    o_err_count,
    output int                    o_pending,
    output int                    o_checked
);

    // one-hot digit enables
    localparam logic [ENABLE_W-1:0] EN_NONE     = 4'b0000;
    localparam logic [ENABLE_W-1:0] EN_MIN_ONES = 4'b0001;
    localparam logic [ENABLE_W-1:0] EN_MIN_TENS = 4'b0010;
    localparam logic [ENABLE_W-1:0] EN_HR_ONES  = 4'b0100;
    localparam logic [ENABLE_W-1:0] EN_HR_TENS  = 4'b1000;
    localparam int                  MAX_REPORTS = 10;

    // decimal digit to segments, bit0 is segment a
    localparam logic [SEG_W-1:0] SEG_ROM [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed {
        logic [ENABLE_W-1:0] en;
        logic [SEG_W-1:0]    seg;
    } t_frame;

    // model state and registers
    logic [TICK_MS_W-1:0] tick_ms;
    logic [SPLASH_W-1:0]  splash_ms;
    logic [1:0]           mode;
    logic                 splash_phase;
    logic [1:0]           digit_sel;
    logic [ELAPSED_W-1:0] splash_elapsed;
    logic [HOURS_W-1:0]   hours;
    logic [SEG_W-1:0]     last_seg;

    t_frame frames_due[$];

    // apply one command to the model, return the frame a tick shows
    task automatic step_display(input logic [CMD_W-1:0] cmd, input logic [MINUTES_W-1:0] mc,
                                input logic [HOURS_W-1:0] hv, output bit shown,
                                output t_frame fr);
        int mins;
        logic [ELAPSED_W:0] sum;
        shown = 1'b0;
        fr = '{en: EN_NONE, seg: last_seg};
        case (cmd)
            CMD_TURN_ON:   mode = MODE_SPLASH;
            CMD_TURN_OFF:  mode = MODE_STOPPED;
            CMD_SET_HOURS: hours = (hv > HOURS_MAX) ? HOURS_MAX : hv;
            CMD_DEC_HOURS: begin
                if (hours != '0) begin
                    hours = hours - 1'b1;
                end
            end
            CMD_TICK: begin
                shown = 1'b1;
                // counter of zero or past an hour reads as zero minutes
                if (mc == '0 || mc > MINUTES_PER_HR) begin
                    mins = 0;
                end else begin
                    mins = int'(MINUTES_PER_HR) - int'(mc);
                end
                case (mode)
                    MODE_SPLASH: begin
                        sum = {1'b0, splash_elapsed} + tick_ms;
                        splash_elapsed = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
                        if (splash_phase) begin
                            fr = '{en: EN_HR_ONES, seg: SPLASH_PAT_B};
                        end else begin
                            fr = '{en: EN_MIN_TENS, seg: SPLASH_PAT_A};
                        end
                        splash_phase = ~splash_phase;
                        if (splash_elapsed >= splash_ms) begin
                            splash_elapsed = '0;
                            mode = MODE_RUNNING;
                        end
                    end
                    MODE_RUNNING: begin
                        case (digit_sel)
                            2'd0:    fr = '{en: EN_MIN_ONES, seg: SEG_ROM[mins % 10]};
                            2'd1:    fr = '{en: EN_MIN_TENS, seg: SEG_ROM[mins / 10]};
                            2'd2:    fr = '{en: EN_HR_ONES, seg: SEG_ROM[hours % 10]};
                            default: fr = '{en: EN_HR_TENS, seg: SEG_ROM[hours / 10]};
                        endcase
                        digit_sel = digit_sel + 1'b1;
                    end
                    default: fr = '{en: EN_NONE, seg: last_seg};
                endcase
                last_seg = fr.seg;
            end
            default: ;
        endcase
    endtask

    // compare, then predict, then register writes
    always @(posedge i_clk) begin
        t_frame got;
        t_frame want;
        t_frame fr;
        bit     shown;
        if (!i_rst_n) begin
            tick_ms        = TICK_MS_RESET;
            splash_ms      = SPLASH_MS_RESET;
            mode           = MODE_SPLASH;
            splash_phase   = 1'b0;
            digit_sel      = 2'd0;
            splash_elapsed = '0;
            hours          = '0;
            last_seg       = '0;
            frames_due.delete();
            o_err_count    = 0;
            o_checked      = 0;
        end else begin
            if (i_disp.valid && i_disp.ready) begin
                got = '{en: i_disp.digit_enable, seg: i_disp.segments};
                if (frames_due.size() == 0) begin
                    o_err_count++;
                    if (o_err_count <= MAX_REPORTS) begin
                        $display("%t: display item with none predicted: en=%h seg=%h",
                                 $realtime, got.en, got.seg);
                    end
                end else begin
                    want = frames_due.pop_front();
                    o_checked++;
                    if (got.en !== want.en || got.seg !== want.seg) begin
                        o_err_count++;
                        if (o_err_count <= MAX_REPORTS) begin
                            $display("%t: display item %0d: expected en=%h seg=%h,",
                                     $realtime, o_checked, want.en, want.seg);
                            $display("    got en=%h seg=%h", got.en, got.seg);
                        end
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                step_display(i_cmd.cmd, i_cmd.minutes_counter, i_cmd.hours_value, shown, fr);
                if (shown) begin
                    frames_due.push_back(fr);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TICK_MS:   tick_ms = i_cfg_data[TICK_MS_W-1:0];
                    REG_SPLASH_MS: splash_ms = i_cfg_data[SPLASH_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = frames_due.size();
    end

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        o_checked   = 0;
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the four-digit display driver: a directed pass over commands,
// modes and counter limits, then random command streams under several timing
// registers with random sender and receiver gaps and a long output stall.
// ----------------------------------------------------------------------------
module tb;
    import fdsm_pkg::*;

    localparam int ITEMS_PER_PHASE = 300;
    localparam int NUM_PHASES      = 6;
    localparam int HOLD_CYCLES     = 200;
    localparam int DRAIN_LIMIT     = 5000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fdsm_in_if  cmd_if ();
    fdsm_out_if disp_if ();

    int err_count;
    int pending;
    int checked;
    int item_count;
    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_req;
    int hold_seen;
    int hold_left;

    four_digit_ssd_multiplexer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (cmd_if),
        .o_out       (disp_if)
    );

    fdsm_display_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_cmd       (cmd_if),
        .i_disp      (disp_if),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("four_digit_ssd_multiplexer: mismatch");
        $finish;
    end

    // display receiver: random stalls plus requested long hold-offs
    initial begin
        disp_if.ready = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                disp_if.ready = 1'b0;
                hold_left--;
            end else begin
                disp_if.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // offer one command item, return after it is taken
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [MINUTES_W-1:0] mc,
                            input logic [HOURS_W-1:0] hv);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid           = 1'b1;
        cmd_if.cmd             = cmd;
        cmd_if.minutes_counter = mc;
        cmd_if.hours_value     = hv;
        do @(posedge i_clk); while (!cmd_if.ready);
        item_count++;
        @(negedge i_clk);
    endtask

    // stop offering and wait for every predicted frame to come out
    task automatic drain_results();
        cmd_if.valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    // register write while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_results();
        repeat (2) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    // random command with biased fields
    task automatic send_random_item();
        logic [CMD_W-1:0]     cmd;
        logic [MINUTES_W-1:0] mc;
        logic [HOURS_W-1:0]   hv;
        int                   r;
        r = $urandom_range(0, 99);
        if (r < 64) begin
            cmd = CMD_TICK;
        end else if (r < 70) begin
            cmd = CMD_TURN_ON;
        end else if (r < 74) begin
            cmd = CMD_TURN_OFF;
        end else if (r < 82) begin
            cmd = CMD_SET_HOURS;
        end else if (r < 92) begin
            cmd = CMD_DEC_HOURS;
        end else begin
            cmd = CMD_W'($urandom_range(int'(CMD_DEC_HOURS) + 1, (1 << CMD_W) - 1));
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            mc = '0;
        end else if (r < 20) begin
            mc = MINUTES_W'($urandom_range(int'(MINUTES_PER_HR), (1 << MINUTES_W) - 1));
        end else begin
            mc = MINUTES_W'($urandom_range(1, int'(MINUTES_PER_HR) - 1));
        end
        if ($urandom_range(0, 99) < 15) begin
            hv = HOURS_W'($urandom_range(int'(HOURS_MAX) + 1, (1 << HOURS_W) - 1));
        end else begin
            hv = HOURS_W'($urandom_range(0, int'(HOURS_MAX)));
        end
        send_cmd(cmd, mc, hv);
    endtask

    initial begin
        int guard;
        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = REG_TICK_MS;
        cfg_data               = '0;
        cmd_if.valid           = 1'b0;
        cmd_if.cmd             = CMD_TICK;
        cmd_if.minutes_counter = '0;
        cmd_if.hours_value     = '0;
        item_count             = 0;
        hold_req               = 0;
        snd_idle_pct           = 29;
        rcv_idle_pct           = 52;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: splash patterns under reset registers, hours limits
        send_cmd(CMD_TICK, '0, '0);
        send_cmd(CMD_TICK, '1, '1);
        send_cmd(CMD_SET_HOURS, '0, '1);
        send_cmd(CMD_DEC_HOURS, '0, '0);
        send_cmd(CMD_SET_HOURS, '1, '0);
        send_cmd(CMD_DEC_HOURS, '0, '0);
        for (int c = int'(CMD_DEC_HOURS) + 1; c < (1 << CMD_W); c++) begin
            send_cmd(CMD_W'(c), MINUTES_W'($urandom), HOURS_W'($urandom));
        end
        // stopped repeats the last pattern with no enables
        send_cmd(CMD_TURN_OFF, '0, '0);
        send_cmd(CMD_TICK, '0, '0);
        send_cmd(CMD_TURN_ON, '0, '0);

        // splash ends on the next tick, then every running digit
        write_reg(REG_TICK_MS, CFG_DATA_W'(1023));
        write_reg(REG_SPLASH_MS, CFG_DATA_W'(1));
        send_cmd(CMD_TICK, 6'd30, '0);
        send_cmd(CMD_SET_HOURS, '0, HOURS_MAX);
        send_cmd(CMD_TICK, 6'd0, '0);
        send_cmd(CMD_TICK, 6'd1, '0);
        send_cmd(CMD_TICK, 6'd59, '0);
        send_cmd(CMD_TICK, MINUTES_PER_HR, '0);
        send_cmd(CMD_TICK, MINUTES_PER_HR, '0);
        send_cmd(CMD_TICK, 6'd61, '0);
        send_cmd(CMD_TICK, '1, '0);
        send_cmd(CMD_TURN_OFF, '0, '0);
        send_cmd(CMD_TICK, 6'd7, '0);
        send_cmd(CMD_TURN_ON, '0, '0);

        // random phases under different registers and gap settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph / 2)
                0: begin
                    snd_idle_pct = 29;
                    rcv_idle_pct = 52;
                end
                1: begin
                    snd_idle_pct = 52;
                    rcv_idle_pct = 29;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            case (ph)
                0: begin
                    write_reg(REG_TICK_MS, CFG_DATA_W'(5));
                    write_reg(REG_SPLASH_MS, CFG_DATA_W'(40));
                end
                1: begin
                    // zero registers: splash ends after its first tick
                    write_reg(REG_TICK_MS, '0);
                    write_reg(REG_SPLASH_MS, '0);
                end
                2: begin
                    write_reg(REG_TICK_MS, CFG_DATA_W'(1000));
                    write_reg(REG_SPLASH_MS, '1);
                end
                3: begin
                    // upper data bits land outside the tick register
                    write_reg(REG_TICK_MS, CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
                    write_reg(REG_SPLASH_MS, CFG_DATA_W'($urandom_range(1, 3000)));
                end
                4: begin
                    // zero tick: splash never ends
                    write_reg(REG_TICK_MS, '0);
                    write_reg(REG_SPLASH_MS, CFG_DATA_W'(7000));
                end
                default: begin
                    write_reg(REG_TICK_MS, CFG_DATA_W'(1023));
                    write_reg(REG_SPLASH_MS, CFG_DATA_W'(1));
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 2 && n == 100) begin
                    hold_req++;
                end
                if (ph == 3 && n == 150) begin
                    drain_results();
                    repeat ($urandom_range(1, 20)) @(negedge i_clk);
                end
                send_random_item();
            end
        end

        // wind down
        cmd_if.valid = 1'b0;
        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (4) @(negedge i_clk);
        $display("covered %0d command items and %0d display frames", item_count, checked);
        $display("over splash, running and stopped modes under %0d register settings",
                 NUM_PHASES + 1);
        if (err_count == 0 && pending == 0) begin
            $display("four_digit_ssd_multiplexer: match");
        end else begin
            $display("four_digit_ssd_multiplexer: mismatch");
        end
        $finish;
    end

endmodule
